// ----- hw/rtl/kmau_pkg.sv -----
`timescale 1ns / 1ps
package kmau_pkg;
   localparam logic [1:0] FUNC_LOAD   = 2'd0;
   localparam logic [1:0] FUNC_ASSIGN = 2'd1;
   localparam logic [1:0] FUNC_FINISH = 2'd2;

   typedef struct packed {
      logic load;
      logic dist_start;
      logic dist_step;
      logic accumulate;
      logic div_start;
      logic commit_center;
      logic emit_point;
      logic emit_center;
      logic emit_last;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic x_done;
      logic dist_done;
      logic fin_done;
   } status_type;
endpackage

// ----- hw/rtl/kmau_ctrl.sv -----
`timescale 1ns / 1ps
module kmau_ctrl
   import kmau_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_func,
   input  status_type stat,
   output cmd_type    cmd,
   output logic       busy
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_DIST, ST_ACC, ST_DIV_GO, ST_DIV_WAIT, ST_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_func == FUNC_LOAD) begin
                  cmd.load = 1'b1;
               end else if (req_func == FUNC_ASSIGN) begin
                  cmd.dist_start = 1'b1;
                  state_in = ST_DIST;
               end else if (req_func == FUNC_FINISH) begin
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_DIST: begin
            cmd.dist_step = 1'b1;
            if (stat.dist_done) state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.accumulate = 1'b1;
            cmd.emit_point = 1'b1;
            state_in = ST_DONE;
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (stat.div_done) begin
               cmd.commit_center = 1'b1;
               cmd.emit_center = 1'b1;
               if (stat.fin_done) begin
                  cmd.emit_last = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_DIV_GO;
               end
            end else if (stat.x_done) begin
               state_in = ST_DIV_GO;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);
endmodule

// ----- hw/rtl/kmau_div.sv -----
`timescale 1ns / 1ps
module kmau_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [63:0] dividend_mag,
   input  logic [31:0] divisor,
   output logic [63:0] quotient,
   output logic        done
);
   logic [63:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in, done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; cnt_in = cnt_ff; run_in = run_ff; done_in = 1'b0;
      trial = {r_ff[31:0], q_ff[63]};
      if (go) begin
         q_in = dividend_mag; r_in = '0; cnt_in = 7'd0; run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, divisor}) begin
            r_in = trial - {1'b0, divisor};
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
      q_ff <= q_in; r_ff <= r_in; cnt_ff <= cnt_in;
   end

   assign quotient = q_ff;
   assign done = done_ff;
endmodule

// ----- hw/rtl/kmau_dp.sv -----
`timescale 1ns / 1ps
module kmau_dp
   import kmau_pkg::*;
#(
   parameter int NUM_CENTERS = 8,
   parameter int COORD_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  stat,
   input  logic [2:0]  req_center_index,
   input  logic [31:0] req_coord_x,
   input  logic [31:0] req_coord_y,
   input  logic [2:0]  req_previous_cluster,
   input  logic [63:0] req_payload,
   output logic        rsp_valid,
   output logic [2:0]  rsp_cluster_id,
   output logic        rsp_changed,
   output logic [63:0] rsp_payload_out,
   output logic [31:0] rsp_result_x,
   output logic [31:0] rsp_result_y,
   output logic [31:0] rsp_member_count,
   output logic [31:0] rsp_changed_total,
   output logic        rsp_last
);
   localparam int IW = (NUM_CENTERS > 1) ? $clog2(NUM_CENTERS) : 1;
   localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
   localparam logic signed [63:0] CMAX = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] CMIN = -(64'sd1 <<< (COORD_BITS - 1));

   logic signed [COORD_BITS-1:0] cx_ff [NUM_CENTERS];
   logic signed [COORD_BITS-1:0] cy_ff [NUM_CENTERS];
   logic signed [63:0] sx_ff [NUM_CENTERS];
   logic signed [63:0] sy_ff [NUM_CENTERS];
   logic [31:0] pc_ff [NUM_CENTERS];
   logic [31:0] chg_total_ff;

   logic signed [COORD_BITS-1:0] px_ff, py_ff;
   logic [2:0]  prev_ff;
   logic [63:0] pay_ff;
   logic [IW-1:0] k_ff;
   logic [IW-1:0] best_ff;
   logic [64:0] bestd_ff;
   logic        kdone_ff;

   logic signed [COORD_BITS:0] dx, dy;
   logic [COORD_BITS:0] adx, ady;
   logic [64:0] d;

   always_comb begin
      dx = {px_ff[COORD_BITS-1], px_ff} - {cx_ff[k_ff][COORD_BITS-1], cx_ff[k_ff]};
      dy = {py_ff[COORD_BITS-1], py_ff} - {cy_ff[k_ff][COORD_BITS-1], cy_ff[k_ff]};
      adx = dx[COORD_BITS] ? (COORD_BITS+1)'(0) - dx : dx;
      ady = dy[COORD_BITS] ? (COORD_BITS+1)'(0) - dy : dy;
      d = 65'({(64-COORD_BITS)'(0), adx} * {(64-COORD_BITS)'(0), adx})
        + 65'({(64-COORD_BITS)'(0), ady} * {(64-COORD_BITS)'(0), ady});
   end

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] s,
                                                  input logic signed [63:0] v);
      logic signed [63:0] r;
      r = s + v;
      if (!s[63] && !v[63] && r[63]) return {1'b0, {63{1'b1}}};
      if (s[63] && v[63] && !r[63]) return {1'b1, 63'd0};
      return r;
   endfunction

   // Finish sweep: two divisions per centre, x then y.
   logic [IW-1:0] fk_ff;
   logic          fy_ff;
   logic [63:0]   dmag;
   logic [63:0]   q;
   logic          ddone;
   logic signed [63:0] sel_sum;
   logic signed [63:0] qs;
   logic signed [63:0] qc;
   logic signed [COORD_BITS-1:0] newx_ff;

   assign sel_sum = fy_ff ? sy_ff[fk_ff] : sx_ff[fk_ff];
   assign dmag = sel_sum[63] ? 64'd0 - sel_sum : sel_sum;

   kmau_div u_div (
      .clock(clock), .reset(reset), .go(cmd.div_start), .dividend_mag(dmag),
      .divisor(pc_ff[fk_ff]), .quotient(q), .done(ddone)
   );

   always_comb begin
      qs = sel_sum[63] ? 64'sd0 - $signed(q) : $signed(q);
      if (qs > CMAX)      qc = CMAX;
      else if (qs < CMIN) qc = CMIN;
      else                qc = qs;
   end

   assign stat.div_done = ddone && fy_ff;
   assign stat.x_done = ddone && !fy_ff;
   assign stat.dist_done = kdone_ff;
   assign stat.fin_done = (fk_ff == IW'(NUM_CENTERS - 1));

   logic signed [COORD_BITS-1:0] fx, fyv;
   always_comb begin
      if (pc_ff[fk_ff] == 32'd0) begin
         fx = cx_ff[fk_ff]; fyv = cy_ff[fk_ff];
      end else begin
         fx = newx_ff; fyv = qc[COORD_BITS-1:0];
      end
   end

   logic chg;
   assign chg = ({{(8-IW){1'b0}}, best_ff} != {5'd0, prev_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CENTERS; i++) begin
            cx_ff[i] <= '0; cy_ff[i] <= '0; sx_ff[i] <= '0; sy_ff[i] <= '0;
            pc_ff[i] <= '0;
         end
         chg_total_ff <= '0;
         rsp_valid <= 1'b0;
         fk_ff <= '0; fy_ff <= 1'b0; kdone_ff <= 1'b0;
      end else begin
         rsp_valid <= cmd.emit_point || cmd.emit_center;
         if (cmd.load && {5'd0, req_center_index} < 8'(NUM_CENTERS)) begin
            cx_ff[IW'(req_center_index)] <= req_coord_x[COORD_BITS-1:0];
            cy_ff[IW'(req_center_index)] <= req_coord_y[COORD_BITS-1:0];
         end
         if (cmd.dist_start) begin
            px_ff <= req_coord_x[COORD_BITS-1:0];
            py_ff <= req_coord_y[COORD_BITS-1:0];
            prev_ff <= req_previous_cluster; pay_ff <= req_payload;
            k_ff <= '0; kdone_ff <= 1'b0;
         end
         if (cmd.dist_step && !kdone_ff) begin
            if (k_ff == '0 || d < bestd_ff) begin
               bestd_ff <= d; best_ff <= k_ff;
            end
            if (k_ff == IW'(NUM_CENTERS - 1)) kdone_ff <= 1'b1;
            else k_ff <= k_ff + IW'(1);
         end
         if (cmd.accumulate) begin
            sx_ff[best_ff] <= sat_add(sx_ff[best_ff], 64'(px_ff));
            sy_ff[best_ff] <= sat_add(sy_ff[best_ff], 64'(py_ff));
            if (pc_ff[best_ff] != CNT_MAX) pc_ff[best_ff] <= pc_ff[best_ff] + 32'd1;
            if (chg && chg_total_ff != CNT_MAX) chg_total_ff <= chg_total_ff + 32'd1;
            rsp_cluster_id <= 3'(best_ff);
            rsp_changed <= chg;
            rsp_payload_out <= pay_ff;
            rsp_result_x <= 32'(px_ff);
            rsp_result_y <= 32'(py_ff);
            rsp_member_count <= '0;
            rsp_changed_total <= (chg && chg_total_ff != CNT_MAX) ?
                                 chg_total_ff + 32'd1 : chg_total_ff;
            rsp_last <= 1'b1;
         end
         if (ddone && !fy_ff) begin
            newx_ff <= qc[COORD_BITS-1:0];
            fy_ff <= 1'b1;
         end
         if (cmd.commit_center) begin
            cx_ff[fk_ff] <= fx; cy_ff[fk_ff] <= fyv;
            sx_ff[fk_ff] <= '0; sy_ff[fk_ff] <= '0; pc_ff[fk_ff] <= '0;
            fy_ff <= 1'b0;
            rsp_cluster_id <= 3'(fk_ff);
            rsp_changed <= 1'b0;
            rsp_payload_out <= '0;
            rsp_result_x <= 32'(fx);
            rsp_result_y <= 32'(fyv);
            rsp_member_count <= pc_ff[fk_ff];
            rsp_changed_total <= chg_total_ff;
            rsp_last <= cmd.emit_last;
            if (cmd.emit_last) begin
               fk_ff <= '0; chg_total_ff <= '0;
            end else begin
               fk_ff <= fk_ff + IW'(1);
            end
         end
      end
   end
endmodule

// ----- hw/rtl/kmeans_assign_and_update_top.sv -----
`timescale 1ns / 1ps
// 2-D Lloyd k-means engine. A point takes one distance per cycle through a shared
// squared-distance unit, and a finish runs two 64-step restoring divisions per
// centre, giving one result per centre. Results appear for one cycle on rsp_valid
// and cannot be stalled; start is taken only while busy is low.
module kmeans_assign_and_update_top
   import kmau_pkg::*;
#(
   parameter int NUM_CENTERS = 8,
   parameter int COORD_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [2:0]  req_center_index,
   input  logic [31:0] req_coord_x,
   input  logic [31:0] req_coord_y,
   input  logic [2:0]  req_previous_cluster,
   input  logic [63:0] req_payload,
   output logic        rsp_valid,
   output logic [2:0]  rsp_cluster_id,
   output logic        rsp_changed,
   output logic [63:0] rsp_payload_out,
   output logic [31:0] rsp_result_x,
   output logic [31:0] rsp_result_y,
   output logic [31:0] rsp_member_count,
   output logic [31:0] rsp_changed_total,
   output logic        rsp_last
);
   cmd_type    cmd;
   status_type stat;

   kmau_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_func(req_func),
      .stat(stat), .cmd(cmd), .busy(busy)
   );

   kmau_dp #(.NUM_CENTERS(NUM_CENTERS), .COORD_BITS(COORD_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_center_index(req_center_index), .req_coord_x(req_coord_x),
      .req_coord_y(req_coord_y), .req_previous_cluster(req_previous_cluster),
      .req_payload(req_payload), .rsp_valid(rsp_valid),
      .rsp_cluster_id(rsp_cluster_id), .rsp_changed(rsp_changed),
      .rsp_payload_out(rsp_payload_out), .rsp_result_x(rsp_result_x),
      .rsp_result_y(rsp_result_y), .rsp_member_count(rsp_member_count),
      .rsp_changed_total(rsp_changed_total), .rsp_last(rsp_last)
   );
endmodule
